// ----- rtl/arlc_pkg.sv -----
`default_nettype none
package arlc_pkg;

    localparam int MAX_EXPECT_LEN = 8;
    localparam int WINDOW_LEN     = 17;
    localparam int PATTERN_W      = 64;
    localparam int LEN_W          = 4;
    localparam int COUNT_W        = 16;
    localparam int ADDR_W         = 4;

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [5*8-1:0]  TXT_ERROR = "ERROR";
    localparam logic [17*8-1:0] TXT_LINK  = "link is not valid";
    localparam logic [4*8-1:0]  TXT_BUSY  = "busy";

    localparam logic REG_PATTERN = 1'b0;
    localparam logic REG_LENGTH  = 1'b1;

    localparam logic REQ_BYTE  = 1'b0;
    localparam logic REQ_START = 1'b1;

    typedef enum logic [1:0] {
        CLASS_EXPECTED = 2'd0,
        CLASS_ERROR    = 2'd1,
        CLASS_BUSY     = 2'd2,
        CLASS_OTHER    = 2'd3
    } arlc_class_t;

    typedef logic [WINDOW_LEN-1:0][7:0] arlc_window_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } arlc_item_t;

    typedef struct packed {
        arlc_class_t        line_class;
        logic [COUNT_W-1:0] line_count;
    } arlc_result_t;

    typedef struct packed {
        logic expected;
        logic error;
        logic busy;
    } arlc_hits_t;

endpackage
`default_nettype wire

// ----- rtl/arlc_match.sv -----
`default_nettype none
module arlc_match
    import arlc_pkg::*;
(
    input  wire arlc_window_t         window,
    input  wire logic [PATTERN_W-1:0] expected_pattern,
    input  wire logic [LEN_W-1:0]     expected_length,
    output arlc_hits_t                hits
);

    logic [LEN_W-1:0]        len_sat;
    logic [LEN_W-1:0]        eff_len;
    logic [MAX_EXPECT_LEN:0] match_len;

    // effective length: saturate, then stop at first zero pattern byte
    always_comb
    begin
        logic found;
        found   = 1'b0;
        len_sat = (expected_length > LEN_W'(MAX_EXPECT_LEN)) ?
                  LEN_W'(MAX_EXPECT_LEN) : expected_length;
        eff_len = len_sat;
        for (int k = 0; k < MAX_EXPECT_LEN; k++)
        begin
            if (!found && (LEN_W'(k) < len_sat) &&
                (expected_pattern[8*k +: 8] == CHAR_NUL))
            begin
                found   = 1'b1;
                eff_len = LEN_W'(k);
            end
        end
    end

    // match for every candidate length, newest byte at window[0]
    always_comb
    begin
        match_len[0] = 1'b1;
        for (int l = 1; l <= MAX_EXPECT_LEN; l++)
        begin
            match_len[l] = 1'b1;
            for (int k = 0; k < l; k++)
            begin
                if (window[l-1-k] != expected_pattern[8*k +: 8])
                    match_len[l] = 1'b0;
            end
        end
    end

    always_comb
    begin
        hits.expected = match_len[eff_len];
        hits.error    = (window[4:0] == TXT_ERROR) || (window[16:0] == TXT_LINK);
        hits.busy     = (window[3:0] == TXT_BUSY);
    end

endmodule
`default_nettype wire

// ----- rtl/arlc_core.sv -----
`default_nettype none
module arlc_core
    import arlc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire arlc_item_t           item,
    input  wire logic [PATTERN_W-1:0] expected_pattern,
    input  wire logic [LEN_W-1:0]     expected_length,
    output logic                      produce,
    output arlc_result_t              result
);

    arlc_window_t       window_reg, window_next;
    arlc_window_t       window_shift;
    logic               seen_expected_reg, seen_expected_next;
    logic               seen_error_reg, seen_error_next;
    logic               seen_busy_reg, seen_busy_next;
    logic               truncated_reg, truncated_next;
    logic               done_reg, done_next;
    logic [COUNT_W-1:0] lines_reg, lines_next;
    arlc_hits_t         hits;
    logic               empty_pat;

    assign window_shift = {window_reg[WINDOW_LEN-2:0], item.rx_byte};
    assign empty_pat    = (expected_length == '0) || (expected_pattern[7:0] == CHAR_NUL);

    arlc_match u_match (
        .window           (window_shift),
        .expected_pattern (expected_pattern),
        .expected_length  (expected_length),
        .hits             (hits)
    );

    always_comb
    begin
        window_next        = window_reg;
        seen_expected_next = seen_expected_reg;
        seen_error_next    = seen_error_reg;
        seen_busy_next     = seen_busy_reg;
        truncated_next     = truncated_reg;
        done_next          = done_reg;
        lines_next         = lines_reg;
        produce            = 1'b0;
        result.line_class  = CLASS_OTHER;
        result.line_count  = lines_reg;
        if (fire)
        begin
            if (item.req_type == REQ_START)
            begin
                window_next        = '0;
                seen_expected_next = 1'b0;
                seen_error_next    = 1'b0;
                seen_busy_next     = 1'b0;
                truncated_next     = 1'b0;
                done_next          = 1'b0;
                lines_next         = '0;
            end
            else if (!done_reg)
            begin
                if (!truncated_reg)
                begin
                    if (item.rx_byte == CHAR_NUL)
                    begin
                        truncated_next = 1'b1;
                    end
                    else
                    begin
                        window_next        = window_shift;
                        seen_expected_next = seen_expected_reg | hits.expected;
                        seen_error_next    = seen_error_reg | hits.error;
                        seen_busy_next     = seen_busy_reg | hits.busy;
                    end
                end
                if (item.rx_byte == CHAR_NEWLINE)
                begin
                    if (lines_reg != '1)
                        lines_next = lines_reg + COUNT_W'(1);
                    produce           = 1'b1;
                    result.line_count = lines_next;
                    if (seen_expected_next || empty_pat)
                        result.line_class = CLASS_EXPECTED;
                    else if (seen_error_next)
                        result.line_class = CLASS_ERROR;
                    else if (seen_busy_next)
                        result.line_class = CLASS_BUSY;
                    else
                        result.line_class = CLASS_OTHER;
                    done_next          = (result.line_class == CLASS_EXPECTED);
                    window_next        = '0;
                    seen_expected_next = 1'b0;
                    seen_error_next    = 1'b0;
                    seen_busy_next     = 1'b0;
                    truncated_next     = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg        <= '0;
            seen_expected_reg <= 1'b0;
            seen_error_reg    <= 1'b0;
            seen_busy_reg     <= 1'b0;
            truncated_reg     <= 1'b0;
            done_reg          <= 1'b0;
            lines_reg         <= '0;
        end
        else
        begin
            window_reg        <= window_next;
            seen_expected_reg <= seen_expected_next;
            seen_error_reg    <= seen_error_next;
            seen_busy_reg     <= seen_busy_next;
            truncated_reg     <= truncated_next;
            done_reg          <= done_next;
            lines_reg         <= lines_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/at_response_line_classifier.sv -----
// Modem reply line classifier.
// Input channel (in_valid/in_ready): req_type 1 starts a new command and
// clears the line count; req_type 0 carries one received byte in rx_byte.
// Output channel (out_valid/out_ready): one item per newline, up to an expected line,
// with the line class (expected, error, busy, other) and the saturating line count.
// Configuration over APB: expected pattern at 0x0, expected length at 0x8;
// write only while the block is idle.
// An accepted item is registered, then classified once the output register
// can take it, and the result is loaded into the output register. One item
// per cycle is sustained while the receiver does not stall; the window
// match and the class decision are combinational on the input register.
// If the receiver stalls, the output register holds its item and the input
// register waits behind it, so in_ready drops only while both are full.
// Reset clears the window, flags, count and the ready-for-command state and
// restores the default expected reply; no item is held after reset.
`default_nettype none
module at_response_line_classifier
    import arlc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 req_type,
    input  wire logic [7:0]           rx_byte,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [1:0]                line_class,
    output logic [COUNT_W-1:0]        line_count,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_W-1:0]    paddr,
    input  wire logic [PATTERN_W-1:0] pwdata,
    output logic [PATTERN_W-1:0]      prdata,
    output logic                      pready
);

    logic [PATTERN_W-1:0] pattern_reg;
    logic [LEN_W-1:0]     length_reg;
    logic                 s1_valid_reg, s1_valid_next;
    arlc_item_t           s1_item_reg;
    logic                 out_valid_reg, out_valid_next;
    arlc_result_t         out_result_reg;
    logic                 advance;
    logic                 produce;
    arlc_result_t         result;
    logic                 wr_en;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite && pready;
    assign prdata   = (paddr[ADDR_W-1] == REG_LENGTH) ?
                      {{(PATTERN_W-LEN_W){1'b0}}, length_reg} : pattern_reg;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = produce;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    arlc_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .fire             (advance),
        .item             (s1_item_reg),
        .expected_pattern (pattern_reg),
        .expected_length  (length_reg),
        .produce          (produce),
        .result           (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg   <= PATTERN_W'(19279);
            length_reg    <= LEN_W'(2);
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                unique case (paddr[ADDR_W-1])
                    REG_PATTERN: pattern_reg <= pwdata;
                    REG_LENGTH:  length_reg  <= pwdata[LEN_W-1:0];
                    default:     pattern_reg <= pattern_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg.req_type <= req_type;
            s1_item_reg.rx_byte  <= rx_byte;
        end
        if (advance && produce)
            out_result_reg <= result;
    end

    assign out_valid  = out_valid_reg;
    assign line_class = out_result_reg.line_class;
    assign line_count = out_result_reg.line_count;

endmodule
`default_nettype wire

// ----- rtl/arlc_checker.sv -----
`default_nettype none
module arlc_checker
    import arlc_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [1:0]         line_class,
    input wire logic [COUNT_W-1:0] line_count
);

    // input side only blocks behind a stalled result
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("in_ready low without a stalled result");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(line_class) && $stable(line_count)))
        else $error("stalled result changed");

    // every result counts its own line
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (line_count != '0))
        else $error("result with zero line count");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid after reset");

endmodule

bind at_response_line_classifier arlc_checker u_arlc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .line_class (line_class),
    .line_count (line_count)
);
`default_nettype wire

// ----- test/tb_top.sv -----
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import arlc_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int CHOKE_CYCLES  = 300;
    localparam int PHASE_ITEMS   = 185;

    localparam logic [39:0]  ERROR_TXT = "ERROR";
    localparam logic [135:0] LINK_TXT  = "link is not valid";
    localparam logic [31:0]  BUSY_TXT  = "busy";
    // "SEND OK\n" with its first character in the low byte
    localparam logic [63:0]  SEND_OK_PAT = "\nKO DNES";
    localparam logic [63:0]  OK_PAT      = 64'h4B4F;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 req_type = 1'b0;
    logic [7:0]           rx_byte = 8'h00;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [1:0]           line_class;
    logic [COUNT_W-1:0]   line_count;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [PATTERN_W-1:0] pwdata = '0;
    logic [PATTERN_W-1:0] prdata;
    logic                 pready;

    arlc_item_t   rx_stream[$];
    arlc_result_t expected_lines[$];
    int           bad_lines = 0;
    int           send_gap = 0;
    int           recv_gap = 0;
    bit           steady = 1'b0;
    bit           choke_go = 1'b0;
    logic         rx_choke = 1'b0;

    // predictor state
    logic [PATTERN_W-1:0] cfg_pattern = OK_PAT;
    logic [LEN_W-1:0]     cfg_length = 4'd2;
    arlc_window_t         win = '0;
    bit                   hit_exp = 1'b0;
    bit                   hit_err = 1'b0;
    bit                   hit_busy = 1'b0;
    bit                   cut_line = 1'b0;
    bit                   cmd_done = 1'b0;
    logic [COUNT_W-1:0]   line_total = '0;

    at_response_line_classifier i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .line_class (line_class),
        .line_count (line_count),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5ns clk = ~clk;

    function automatic void clear_line_state();
        win = '0;
        hit_exp = 1'b0;
        hit_err = 1'b0;
        hit_busy = 1'b0;
        cut_line = 1'b0;
    endfunction

    function automatic bit classify_item(input arlc_item_t it, output arlc_result_t res);
        int unsigned n;
        int          k;
        bit          same;
        res = '0;
        if (it.req_type == REQ_START)
        begin
            clear_line_state();
            cmd_done = 1'b0;
            line_total = '0;
            return 1'b0;
        end
        if (cmd_done)
            return 1'b0;
        if (!cut_line)
        begin
            if (it.rx_byte == CHAR_NUL)
                cut_line = 1'b1;
            else
            begin
                win = {win[WINDOW_LEN-2:0], it.rx_byte};
                n = (cfg_length > MAX_EXPECT_LEN) ? MAX_EXPECT_LEN : cfg_length;
                for (k = 0; k < MAX_EXPECT_LEN; k++)
                    if (k < n && cfg_pattern[8*k +: 8] == 8'h00)
                        n = k;
                same = 1'b1;
                for (k = 0; k < MAX_EXPECT_LEN; k++)
                    if (k < n && win[n-1-k] != cfg_pattern[8*k +: 8])
                        same = 1'b0;
                if (same)
                    hit_exp = 1'b1;
                if (win[4:0] == ERROR_TXT || win == LINK_TXT)
                    hit_err = 1'b1;
                if (win[3:0] == BUSY_TXT)
                    hit_busy = 1'b1;
            end
        end
        if (it.rx_byte != CHAR_NEWLINE)
            return 1'b0;
        if (line_total != '1)
            line_total++;
        if (hit_exp || cfg_length == '0 || cfg_pattern[7:0] == 8'h00)
            res.line_class = CLASS_EXPECTED;
        else if (hit_err)
            res.line_class = CLASS_ERROR;
        else if (hit_busy)
            res.line_class = CLASS_BUSY;
        else
            res.line_class = CLASS_OTHER;
        res.line_count = line_total;
        if (res.line_class == CLASS_EXPECTED)
            cmd_done = 1'b1;
        clear_line_state();
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic void report_miss(input string what, input arlc_result_t want,
                                        input arlc_result_t got);
        bad_lines++;
        if (bad_lines <= 10)
            $display("%t line result %s: expected class %0d count %0d, got class %0d count %0d",
                     $time, what, want.line_class, want.line_count,
                     got.line_class, got.line_count);
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        arlc_item_t it;
        it.req_type = REQ_BYTE;
        it.rx_byte = b;
        rx_stream.push_back(it);
    endfunction

    function automatic void push_start();
        arlc_item_t it;
        it.req_type = REQ_START;
        it.rx_byte = 8'($urandom_range(0, 255));
        rx_stream.push_back(it);
    endfunction

    function automatic void push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    // a reply line built from fragments, with an optional command start before it
    function automatic void push_line(input int start_pct);
        int parts;
        int i;
        int k;
        int n;
        if ($urandom_range(0, 99) < start_pct)
            push_start();
        parts = $urandom_range(0, 3);
        for (i = 0; i < parts; i++)
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    n = (cfg_length > MAX_EXPECT_LEN) ? MAX_EXPECT_LEN : cfg_length;
                    for (k = 0; k < n; k++)
                        push_byte(cfg_pattern[8*k +: 8]);
                end
                2: push_text("ERROR");
                3: push_text("link is not valid");
                4: push_text("busy");
                5:
                    case ($urandom_range(0, 3))
                        0: push_text("ERRO");
                        1: push_text("link is not vali");
                        2: push_text("bus");
                        default: push_text("RROR");
                    endcase
                6: push_byte(CHAR_NUL);
                7: push_byte(8'($urandom_range(0, 255)));
                default:
                begin
                    n = $urandom_range(1, 6);
                    for (k = 0; k < n; k++)
                        push_byte(8'($urandom_range(8'h20, 8'h7e)));
                end
            endcase
        push_byte(CHAR_NEWLINE);
    endfunction

    task automatic drain();
        while (rx_stream.size() != 0 || in_valid || expected_lines.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [PATTERN_W-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 3;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_PATTERN)
            cfg_pattern = data;
        else
            cfg_length = data[LEN_W-1:0];
    endtask

    task automatic run_phase(input logic [63:0] pat, input logic [3:0] len, input int n,
                             input int start_pct, input bit calm, input bit hold);
        int r;
        cfg_write(REG_PATTERN, pat);
        cfg_write(REG_LENGTH, 64'(len));
        steady = calm;
        @(negedge clk);
        while (rx_stream.size() < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                push_byte(8'($urandom_range(0, 255)));
            else if (r < 10)
                push_start();
            else
                push_line(start_pct);
        end
        if (hold)
            choke_go = 1'b1;
        drain();
    endtask

    // item sender
    always @(posedge clk)
    begin : item_sender
        arlc_item_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (rx_stream.size() > 0)
            begin
                nxt = rx_stream.pop_front();
                in_valid <= 1'b1;
                req_type <= nxt.req_type;
                rx_byte <= nxt.rx_byte;
                send_gap <= pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // prediction on each accepted item
    always @(posedge clk)
    begin : item_tracker
        arlc_item_t   acc;
        arlc_result_t res;
        if (rst_n && in_valid && in_ready)
        begin
            acc.req_type = req_type;
            acc.rx_byte = rx_byte;
            if (classify_item(acc, res))
                expected_lines.push_back(res);
        end
    end

    // result receiver and checker
    always @(posedge clk)
    begin : line_monitor
        arlc_result_t got;
        arlc_result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                got.line_class = arlc_class_t'(line_class);
                got.line_count = line_count;
                if (expected_lines.size() == 0)
                    report_miss("without prediction", '0, got);
                else
                begin
                    want = expected_lines.pop_front();
                    if (got.line_class !== want.line_class ||
                        got.line_count !== want.line_count)
                        report_miss("mismatch", want, got);
                end
            end
            if (rx_choke)
                out_ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                out_ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                recv_gap <= pick_gap();
            end
        end
    end

    // long receiver stall so the block backs up into its input
    initial
    begin
        wait (choke_go);
        @(posedge clk);
        rx_choke <= 1'b1;
        repeat (CHOKE_CYCLES) @(posedge clk);
        rx_choke <= 1'b0;
    end

    initial
    begin
        #20ms;
        $display("FAIL at_response_line_classifier");
        $finish;
    end

    initial
    begin
        int k;
        logic [63:0] pat;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed items with the settings from reset
        push_start();
        push_text("busy\n");
        push_text("ERROR\n");
        push_byte(CHAR_NUL);
        push_text("OK\n");
        push_text("OK\n");
        push_text("z\n");
        push_start();
        push_byte(8'hFF);
        push_byte(CHAR_NEWLINE);
        drain();

        run_phase(OK_PAT, 4'd2, PHASE_ITEMS, 25, 1'b0, 1'b0);
        run_phase(SEND_OK_PAT, 4'd8, PHASE_ITEMS, 25, 1'b0, 1'b0);
        run_phase('1, 4'd15, PHASE_ITEMS, 10, 1'b1, 1'b1);
        run_phase(OK_PAT, 4'd0, PHASE_ITEMS, 80, 1'b0, 1'b0);
        run_phase('0, 4'd8, PHASE_ITEMS, 80, 1'b0, 1'b0);
        run_phase({32'($urandom), 8'h7A, 8'h00, 16'h4B4F}, 4'd5, PHASE_ITEMS, 30, 1'b0, 1'b0);
        for (k = 0; k < 8; k++)
            pat[8*k +: 8] = 8'($urandom_range(8'h21, 8'h7e));
        run_phase(pat, 4'($urandom_range(0, 15)), PHASE_ITEMS, 40, 1'b1, 1'b0);
        run_phase({32'($urandom), 32'($urandom)}, 4'($urandom_range(1, 8)), PHASE_ITEMS, 40,
                  1'b0, 1'b0);
        run_phase(64'h45, 4'd1, PHASE_ITEMS, 50, 1'b0, 1'b0);

        if (bad_lines == 0 && expected_lines.size() == 0)
            $display("PASS at_response_line_classifier");
        else
            $display("FAIL at_response_line_classifier");
        $finish;
    end

endmodule
`default_nettype wire
